// ===== rtl/core/brest_pkg.sv =====
// ============================================================================
// brest_pkg
// Shared types and constants of the battery runtime estimator.
// ============================================================================
package brest_pkg;

    localparam int HISTORY_DEPTH_DEF = 32;

    localparam int TIME_W  = 32;
    localparam int LEVEL_W = 15;
    localparam int ETA_W   = 15;
    localparam int CFG_W   = 22;
    localparam int IV_W    = 13;
    localparam int RATE_W  = 21;
    localparam int EQ_W    = 22;

    localparam int ALU_W     = 88;
    localparam int ALU_CNT_W = $clog2(ALU_W + 1);

    localparam logic [LEVEL_W-1:0] FULL_LEVEL   = 15'd25472;
    localparam logic [LEVEL_W-1:0] MAX_LEVEL    = 15'd25600;
    localparam logic [TIME_W-1:0]  BOOT_AGE_S   = 32'd1200;
    localparam logic [TIME_W-1:0]  MIN_SPAN_S   = 32'd2100;
    localparam int                 MIN_SAMPLES  = 8;
    localparam logic [ALU_W-1:0]   RATE_MIN     = 88'd16384;
    localparam logic [ALU_W-1:0]   RATE_MAX     = 88'd1966080;
    localparam logic [ALU_W-1:0]   RATE_DROP    = 88'd235929600;
    localparam logic [ALU_W-1:0]   RATE_SCALE   = 88'd1843200;
    localparam logic [ALU_W-1:0]   ETA_SCALE    = 88'd7864320;
    localparam logic [ALU_W-1:0]   ETA_Q8_LIMIT = 88'd2560000;
    localparam int                 JUMP_DROP    = 768;
    localparam int                 JUMP_RISE    = 256;
    localparam int                 FILT_CAP     = 31;
    localparam int                 FILT_ALPHA   = 46;

    localparam logic [CFG_W-1:0] INTERVAL_RESET = 22'd60000;
    localparam logic [IV_W-1:0]  IV_RESET       = 13'd60;
    localparam logic [22:0]      MS_RECIP       = 23'd4294968;

    localparam logic CFG_IDX_INTERVAL = 1'b0;

    typedef enum logic [2:0] {
        ST_RESET    = 3'd0,
        ST_EARLY    = 3'd1,
        ST_JUMP     = 3'd2,
        ST_INTERVAL = 3'd3,
        ST_HISTORY  = 3'd4,
        ST_SLOPE    = 3'd5,
        ST_UPDATED  = 3'd6
    } status_t;

    typedef enum logic {
        ALU_MUL = 1'b0,
        ALU_DIV = 1'b1
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_req_t;

    typedef enum logic [4:0] {
        S_IDLE, S_EVAL, S_FILT, S_SPAN_RD, S_SPAN, S_ACC_RD, S_ACC_T, S_ACC_TP,
        S_ACC_NEXT, S_FIT1, S_FIT2, S_FIT3, S_FIT4, S_FIT5, S_FIT6, S_FIT7,
        S_FIT8, S_FIT9, S_FIT10, S_WAIT, S_DONE
    } fsm_t;

endpackage

// ===== rtl/core/brest_alu.sv =====
// ============================================================================
// brest_alu
// Shared multi-cycle unit: multiply-accumulate one byte of the multiplier per
// cycle, or restoring division one quotient bit per cycle.
// ============================================================================
module brest_alu
    import brest_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  alu_req_t         req,
    input  logic [ALU_W-1:0] opa,
    input  logic [ALU_W-1:0] opb,
    input  logic [ALU_W-1:0] opc,
    output logic             done,
    output logic [ALU_W-1:0] result
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    alu_op_t              op_reg, op_next;
    logic [ALU_CNT_W-1:0] cnt_reg, cnt_next;
    logic [ALU_W-1:0]     acc_reg, acc_next;
    logic [ALU_W-1:0]     x_reg, x_next;
    logic [ALU_W-1:0]     y_reg, y_next;
    logic [ALU_W-1:0]     rem_reg, rem_next;
    logic [7:0]           digit;
    logic [ALU_W:0]       trial;
    logic [ALU_W:0]       diff;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        rem_next  = rem_reg;
        digit     = y_reg[7:0];
        trial     = {rem_reg, x_reg[ALU_W-1]};
        diff      = trial - {1'b0, y_reg};
        if (req.start)
        begin
            busy_next = 1'b1;
            op_next   = req.op;
            x_next    = opa;
            y_next    = opb;
            cnt_next  = ALU_CNT_W'(ALU_W);
            rem_next  = '0;
            acc_next  = (req.op == ALU_MUL) ? opc : '0;
        end
        else if (busy_reg)
        begin
            unique case (op_reg)
                ALU_MUL:
                begin
                    if (y_reg == '0)
                    begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        acc_next = acc_reg + x_reg * digit;
                        x_next   = x_reg << 8;
                        y_next   = y_reg >> 8;
                    end
                end
                ALU_DIV:
                begin
                    if (!diff[ALU_W])
                    begin
                        rem_next = diff[ALU_W-1:0];
                    end
                    else
                    begin
                        rem_next = trial[ALU_W-1:0];
                    end
                    acc_next = {acc_reg[ALU_W-2:0], ~diff[ALU_W]};
                    x_next   = x_reg << 1;
                    cnt_next = cnt_reg - 1'b1;
                    if (cnt_reg == ALU_CNT_W'(1))
                    begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end
                end
                default:
                begin
                    busy_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= ALU_MUL;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        rem_reg <= rem_next;
    end

    assign done   = done_reg;
    assign result = acc_reg;

endmodule

// ===== rtl/core/battery_runtime_estimator_unit.sv =====
// ============================================================================
// battery_runtime_estimator_unit
// Estimates remaining battery runtime from timed charge-level samples.
// A clearing sample goes from S_EVAL straight to S_DONE; other samples may stop
// in S_FILT or S_SPAN before the fit. A fitted sample adds two multiplications
// per stored sample, whose length is set by the byte counts of the time offset
// and the level, plus the fit, most of it in two 88-bit divisions.
// One transaction is processed at a time; the input is not ready meanwhile,
// and a result that has not been taken holds the next one back.
// Reset clears all estimator state; the history ring is not cleared.
// ============================================================================
module battery_runtime_estimator_unit
    import brest_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // now_seconds[31:0], level[46:32]
    input  logic [0:0]  s_tuser,   // charging[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // eta_minutes[14:0]
    output logic [2:0]  m_tuser,   // status[2:0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IDX_W   = $clog2(HISTORY_DEPTH);
    localparam int CNT_W   = $clog2(HISTORY_DEPTH + 1);
    localparam int SUMT_W  = TIME_W + CNT_W;
    localparam int SUMP_W  = LEVEL_W + CNT_W;
    localparam int SUMTT_W = 2 * TIME_W + CNT_W;
    localparam int SUMTP_W = TIME_W + LEVEL_W + CNT_W;
    localparam int MEM_W   = TIME_W + LEVEL_W;

    fsm_t                state_reg, state_next;
    fsm_t                ret_reg, ret_next;
    logic [CFG_W-1:0]    cfg_reg;
    logic [IV_W-1:0]     min_iv_reg;
    logic [44:0]         iv_prod;
    logic [IV_W-1:0]     iv_q;
    logic                was_chg_reg, was_chg_next;
    logic                fv_reg, fv_next;
    logic [LEVEL_W-1:0]  filt_reg, filt_next;
    logic                est_reg, est_next;
    logic [TIME_W-1:0]   last_store_reg, last_store_next;
    logic [LEVEL_W-1:0]  last_level_reg, last_level_next;
    logic [IDX_W-1:0]    wp_reg, wp_next;
    logic [CNT_W-1:0]    fill_reg, fill_next;
    logic [ETA_W-1:0]    eta_reg, eta_next;
    status_t             status_reg, status_next;
    logic [IDX_W-1:0]    k_reg, k_next;
    logic [CNT_W-1:0]    i_reg, i_next;
    logic                out_valid_reg, out_valid_next;
    logic [ETA_W-1:0]    out_eta_reg;
    status_t             out_status_reg;

    logic [TIME_W-1:0]   now_reg;
    logic                chg_reg;
    logic [LEVEL_W-1:0]  lvl_reg;
    logic [TIME_W-1:0]   oldest_reg, oldest_next;
    logic [TIME_W-1:0]   span_reg, span_next;
    logic [TIME_W-1:0]   t_reg, t_next;
    logic [LEVEL_W-1:0]  p_reg, p_next;
    logic [SUMT_W-1:0]   sum_t_reg, sum_t_next;
    logic [SUMP_W-1:0]   sum_p_reg, sum_p_next;
    logic [SUMTT_W-1:0]  sum_tt_reg, sum_tt_next;
    logic [SUMTP_W-1:0]  sum_tp_reg, sum_tp_next;
    logic [ALU_W-1:0]    den_reg, den_next;
    logic [RATE_W-1:0]   rate_reg, rate_next;

    logic [MEM_W-1:0]    hist_mem [HISTORY_DEPTH];
    logic [MEM_W-1:0]    rd_reg;
    logic                mem_we;
    logic [TIME_W-1:0]   rd_time;
    logic [LEVEL_W-1:0]  rd_level;

    alu_req_t            alu_req;
    logic [ALU_W-1:0]    alu_a, alu_b, alu_c, alu_res;
    logic                alu_done;

    logic                cfg_wr;
    logic                accept;
    logic                do_clear, clear_mark, full;
    logic [IDX_W-1:0]    wp_inc, k_inc;
    logic [CNT_W-1:0]    fill_inc;

    logic signed [16:0]  f_diff;
    logic signed [23:0]  f_prod, f_mag, f_rmag, f_new, f_cap;
    logic [LEVEL_W-1:0]  fil;
    logic signed [16:0]  delta;
    logic [TIME_W-1:0]   span_now;
    logic [TIME_W-1:0]   t_now;
    logic [EQ_W-1:0]     eq;
    logic signed [24:0]  base, e_diff, e_rnd, e_s;

    brest_alu u_alu
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (alu_req),
        .opa    (alu_a),
        .opb    (alu_b),
        .opc    (alu_c),
        .done   (alu_done),
        .result (alu_res)
    );

    assign cfg_wr  = psel && penable && pwrite && pready && (paddr[2] == CFG_IDX_INTERVAL);
    assign pready  = 1'b1;
    assign prdata  = (paddr[2] == CFG_IDX_INTERVAL) ? 32'(cfg_reg) : '0;
    assign iv_prod = cfg_reg * MS_RECIP;
    assign iv_q    = iv_prod[44:32];

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_eta_reg};
    assign m_tuser  = out_status_reg;

    assign rd_time  = rd_reg[TIME_W-1:0];
    assign rd_level = rd_reg[MEM_W-1:TIME_W];
    assign wp_inc   = (wp_reg == IDX_W'(HISTORY_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
    assign k_inc    = (k_reg == IDX_W'(HISTORY_DEPTH - 1)) ? '0 : k_reg + 1'b1;
    assign fill_inc = (fill_reg == CNT_W'(HISTORY_DEPTH)) ? fill_reg : fill_reg + 1'b1;

    always_comb
    begin
        f_diff = $signed({2'b00, lvl_reg}) - $signed({2'b00, filt_reg});
        f_prod = 24'(f_diff) * 24'sd46;
        f_mag  = f_prod[23] ? -f_prod : f_prod;
        f_rmag = (f_mag + 24'sd128) >>> 8;
        f_new  = $signed({9'd0, filt_reg}) + (f_prod[23] ? -f_rmag : f_rmag);
        f_cap  = $signed({9'd0, filt_reg}) + 24'(FILT_CAP);
        if (f_new > f_cap)
        begin
            f_new = f_cap;
        end
        if (f_new < 24'sd0)
        begin
            f_new = 24'sd0;
        end
        if (f_new > $signed({9'd0, MAX_LEVEL}))
        begin
            f_new = $signed({9'd0, MAX_LEVEL});
        end
        fil   = fv_reg ? f_new[LEVEL_W-1:0] : lvl_reg;
        delta = $signed({2'b00, fil}) - $signed({2'b00, last_level_reg});
    end

    assign span_now = now_reg - rd_time;
    assign t_now    = rd_time - oldest_reg;
    assign eq       = alu_res[EQ_W-1:0];

    always_comb
    begin
        base   = $signed({3'b000, eta_reg[ETA_W-2:0], 8'd0});
        e_diff = $signed({3'b000, eq}) - base;
        e_rnd  = e_diff[24] ? -((-e_diff + 25'sd2) >>> 2) : ((e_diff + 25'sd2) >>> 2);
        e_s    = base + e_rnd + 25'sd128;
    end

    always_comb
    begin
        state_next      = state_reg;
        ret_next        = ret_reg;
        was_chg_next    = was_chg_reg;
        fv_next         = fv_reg;
        filt_next       = filt_reg;
        est_next        = est_reg;
        last_store_next = last_store_reg;
        last_level_next = last_level_reg;
        wp_next         = wp_reg;
        fill_next       = fill_reg;
        eta_next        = eta_reg;
        status_next     = status_reg;
        k_next          = k_reg;
        i_next          = i_reg;
        oldest_next     = oldest_reg;
        span_next       = span_reg;
        t_next          = t_reg;
        p_next          = p_reg;
        sum_t_next      = sum_t_reg;
        sum_p_next      = sum_p_reg;
        sum_tt_next     = sum_tt_reg;
        sum_tp_next     = sum_tp_reg;
        den_next        = den_reg;
        rate_next       = rate_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        mem_we          = 1'b0;
        do_clear        = 1'b0;
        clear_mark      = 1'b0;
        full            = chg_reg || (lvl_reg >= FULL_LEVEL);
        alu_req         = '{start: 1'b0, op: ALU_MUL};
        alu_a           = '0;
        alu_b           = '0;
        alu_c           = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (full || lvl_reg == '0)
                begin
                    do_clear    = 1'b1;
                    clear_mark  = full;
                    status_next = ST_RESET;
                    state_next  = S_DONE;
                end
                else
                begin
                    do_clear   = was_chg_reg;
                    state_next = S_FILT;
                end
            end
            S_FILT:
            begin
                state_next = S_DONE;
                if (now_reg < BOOT_AGE_S)
                begin
                    status_next = ST_EARLY;
                end
                else
                begin
                    fv_next = 1'b1;
                    if (fill_reg != '0
                        && (delta < -17'sd768 || delta > 17'sd256))
                    begin
                        status_next = ST_JUMP;
                    end
                    else
                    begin
                        filt_next = fil;
                        if (last_store_reg != '0 && (now_reg - last_store_reg) <
                            TIME_W'(min_iv_reg))
                        begin
                            status_next = ST_INTERVAL;
                        end
                        else
                        begin
                            last_store_next = now_reg;
                            last_level_next = fil;
                            mem_we          = 1'b1;
                            wp_next         = wp_inc;
                            fill_next       = fill_inc;
                            if (fill_inc < CNT_W'(MIN_SAMPLES))
                            begin
                                status_next = ST_HISTORY;
                            end
                            else
                            begin
                                k_next = (fill_inc == CNT_W'(HISTORY_DEPTH)) ? wp_inc : '0;
                                state_next = S_SPAN_RD;
                            end
                        end
                    end
                end
            end
            S_SPAN_RD:
            begin
                state_next = S_SPAN;
            end
            S_SPAN:
            begin
                oldest_next = rd_time;
                span_next   = span_now;
                if (span_now < MIN_SPAN_S)
                begin
                    status_next = ST_HISTORY;
                    state_next  = S_DONE;
                end
                else
                begin
                    sum_t_next  = '0;
                    sum_p_next  = '0;
                    sum_tt_next = '0;
                    sum_tp_next = '0;
                    i_next      = '0;
                    state_next  = S_ACC_RD;
                end
            end
            S_ACC_RD:
            begin
                state_next = S_ACC_T;
            end
            S_ACC_T:
            begin
                t_next     = t_now;
                p_next     = rd_level;
                sum_t_next = sum_t_reg + SUMT_W'(t_now);
                sum_p_next = sum_p_reg + SUMP_W'(rd_level);
                alu_req    = '{start: 1'b1, op: ALU_MUL};
                alu_a      = ALU_W'(t_now);
                alu_b      = ALU_W'(t_now);
                alu_c      = ALU_W'(sum_tt_reg);
                ret_next   = S_ACC_TP;
                state_next = S_WAIT;
            end
            S_ACC_TP:
            begin
                sum_tt_next = alu_res[SUMTT_W-1:0];
                alu_req     = '{start: 1'b1, op: ALU_MUL};
                alu_a       = ALU_W'(t_reg);
                alu_b       = ALU_W'(p_reg);
                alu_c       = ALU_W'(sum_tp_reg);
                ret_next    = S_ACC_NEXT;
                state_next  = S_WAIT;
            end
            S_ACC_NEXT:
            begin
                sum_tp_next = alu_res[SUMTP_W-1:0];
                i_next      = i_reg + 1'b1;
                k_next      = k_inc;
                state_next  = (i_reg + 1'b1 == fill_reg) ? S_FIT1 : S_ACC_RD;
            end
            S_FIT1:
            begin
                alu_req    = '{start: 1'b1, op: ALU_MUL};
                alu_a      = ALU_W'(sum_t_reg);
                alu_b      = ALU_W'(sum_t_reg);
                ret_next   = S_FIT2;
                state_next = S_WAIT;
            end
            S_FIT2:
            begin
                alu_req    = '{start: 1'b1, op: ALU_MUL};
                alu_a      = ALU_W'(sum_tt_reg);
                alu_b      = ALU_W'(fill_reg);
                alu_c      = '0 - alu_res;
                ret_next   = S_FIT3;
                state_next = S_WAIT;
            end
            S_FIT3:
            begin
                den_next = alu_res;
                if (alu_res == '0)
                begin
                    status_next = ST_HISTORY;
                    state_next  = S_DONE;
                end
                else
                begin
                    alu_req    = '{start: 1'b1, op: ALU_MUL};
                    alu_a      = ALU_W'(sum_t_reg);
                    alu_b      = ALU_W'(sum_p_reg);
                    ret_next   = S_FIT4;
                    state_next = S_WAIT;
                end
            end
            S_FIT4:
            begin
                alu_req    = '{start: 1'b1, op: ALU_MUL};
                alu_a      = ALU_W'(sum_tp_reg);
                alu_b      = ALU_W'(fill_reg);
                alu_c      = '0 - alu_res;
                ret_next   = S_FIT5;
                state_next = S_WAIT;
            end
            S_FIT5:
            begin
                if (!alu_res[ALU_W-1])
                begin
                    status_next = ST_SLOPE;
                    state_next  = S_DONE;
                end
                else
                begin
                    alu_req    = '{start: 1'b1, op: ALU_MUL};
                    alu_a      = '0 - alu_res;
                    alu_b      = RATE_SCALE;
                    alu_c      = den_reg;
                    ret_next   = S_FIT6;
                    state_next = S_WAIT;
                end
            end
            S_FIT6:
            begin
                alu_req    = '{start: 1'b1, op: ALU_DIV};
                alu_a      = alu_res;
                alu_b      = den_reg << 1;
                ret_next   = S_FIT7;
                state_next = S_WAIT;
            end
            S_FIT7:
            begin
                if (alu_res < RATE_MIN || alu_res > RATE_MAX)
                begin
                    status_next = ST_SLOPE;
                    state_next  = S_DONE;
                end
                else
                begin
                    rate_next  = alu_res[RATE_W-1:0];
                    alu_req    = '{start: 1'b1, op: ALU_MUL};
                    alu_a      = alu_res;
                    alu_b      = ALU_W'(span_reg);
                    ret_next   = S_FIT8;
                    state_next = S_WAIT;
                end
            end
            S_FIT8:
            begin
                if (alu_res < RATE_DROP)
                begin
                    status_next = ST_SLOPE;
                    state_next  = S_DONE;
                end
                else
                begin
                    alu_req    = '{start: 1'b1, op: ALU_MUL};
                    alu_a      = ALU_W'(last_level_reg);
                    alu_b      = ETA_SCALE;
                    alu_c      = ALU_W'(rate_reg);
                    ret_next   = S_FIT9;
                    state_next = S_WAIT;
                end
            end
            S_FIT9:
            begin
                alu_req    = '{start: 1'b1, op: ALU_DIV};
                alu_a      = alu_res;
                alu_b      = ALU_W'({rate_reg, 1'b0});
                ret_next   = S_FIT10;
                state_next = S_WAIT;
            end
            S_FIT10:
            begin
                state_next = S_DONE;
                if (alu_res == '0 || alu_res >= ETA_Q8_LIMIT)
                begin
                    status_next = ST_SLOPE;
                end
                else
                begin
                    status_next = ST_UPDATED;
                    if (est_reg && !eta_reg[ETA_W-1])
                    begin
                        eta_next = e_s[ETA_W+7:8];
                    end
                    else
                    begin
                        eta_next = ETA_W'((eq + EQ_W'(128)) >> 8);
                        est_next = 1'b1;
                    end
                end
            end
            S_WAIT:
            begin
                if (alu_done)
                begin
                    state_next = ret_reg;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (do_clear)
        begin
            was_chg_next    = clear_mark;
            fv_next         = 1'b0;
            filt_next       = '0;
            est_next        = 1'b0;
            last_store_next = '0;
            wp_next         = '0;
            fill_next       = '0;
            eta_next        = '1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ret_reg        <= S_IDLE;
            cfg_reg        <= INTERVAL_RESET;
            min_iv_reg     <= IV_RESET;
            was_chg_reg    <= 1'b0;
            fv_reg         <= 1'b0;
            filt_reg       <= '0;
            est_reg        <= 1'b0;
            last_store_reg <= '0;
            last_level_reg <= '0;
            wp_reg         <= '0;
            fill_reg       <= '0;
            eta_reg        <= '1;
            status_reg     <= ST_RESET;
            k_reg          <= '0;
            i_reg          <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ret_reg        <= ret_next;
            if (cfg_wr)
            begin
                cfg_reg <= pwdata[CFG_W-1:0];
            end
            min_iv_reg     <= (iv_q == '0) ? IV_W'(1) : iv_q;
            was_chg_reg    <= was_chg_next;
            fv_reg         <= fv_next;
            filt_reg       <= filt_next;
            est_reg        <= est_next;
            last_store_reg <= last_store_next;
            last_level_reg <= last_level_next;
            wp_reg         <= wp_next;
            fill_reg       <= fill_next;
            eta_reg        <= eta_next;
            status_reg     <= status_next;
            k_reg          <= k_next;
            i_reg          <= i_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            now_reg <= s_tdata[31:0];
            lvl_reg <= s_tdata[46:32];
            chg_reg <= s_tuser[0];
        end
        if (state_reg == S_DONE && (!out_valid_reg || m_tready))
        begin
            out_eta_reg    <= eta_reg;
            out_status_reg <= status_reg;
        end
        if (mem_we)
        begin
            hist_mem[wp_reg] <= {fil, now_reg};
        end
        rd_reg     <= hist_mem[k_reg];
        oldest_reg <= oldest_next;
        span_reg   <= span_next;
        t_reg      <= t_next;
        p_reg      <= p_next;
        sum_t_reg  <= sum_t_next;
        sum_p_reg  <= sum_p_next;
        sum_tt_reg <= sum_tt_next;
        sum_tp_reg <= sum_tp_next;
        den_reg    <= den_next;
        rate_reg   <= rate_next;
    end

endmodule

// ===== rtl/core/brest_checker.sv =====
// ============================================================================
// brest_checker
// Port-level checks of the battery runtime estimator.
// ============================================================================
module brest_checker
    import brest_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        pready
);

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted again while a transaction is in progress");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled output transaction changed");

    a_reset_no_eta: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == ST_RESET |-> m_tdata[14:0] == 15'h7fff)
        else $error("reset status with an estimate present");

    a_updated_eta: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == ST_UPDATED |-> !m_tdata[14])
        else $error("updated status without a valid estimate");

    a_pready_high: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("configuration port not ready");

endmodule

bind battery_runtime_estimator_unit brest_checker u_brest_checker (.*);

// ===== verif/tb_battery_runtime_estimator_unit.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_battery_runtime_estimator_unit
// Self-checking testbench for the battery runtime estimator. A table of
// directed samples is followed by random sessions, mostly discharging, mixed
// with noise. Each output is checked against the table or an in-bench model.
// The sample interval is changed between phases, and both stream sides stall.
// ============================================================================
module tb_battery_runtime_estimator_unit;
    import brest_pkg::*;

    localparam int DEPTH = 32;
    localparam int RANDOM_ITEMS = 1930;

    typedef struct {
        logic [31:0] now;
        logic        chg;
        logic [14:0] lvl;
        bit          known;
        logic [14:0] eta;
        status_t     st;
    } sample_row_t;

    typedef struct {
        logic [14:0] eta;
        status_t     st;
    } estimate_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;    // now_seconds[31:0], level[46:32]
    logic [0:0]  s_tuser = '0;    // charging[0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;         // eta_minutes[14:0]
    logic [2:0]  m_tuser;         // status[2:0]
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    battery_runtime_estimator_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    logic [21:0] interval_ms;
    logic        was_charging, filt_valid, est_valid;
    int          filt_level;
    logic [31:0] last_store;
    logic [31:0] hist_time [DEPTH];
    int          hist_level [DEPTH];
    int          wr_ptr, fill;
    int          eta_min;

    estimate_t   pending_estimates[$];
    int          errors = 0;
    int          items_sent = 0;
    int          status_seen [7];
    int          src_idle = 0;
    int          snk_idle = 0;

    function automatic int round_div(input int num, input int den);
        if (num >= 0)
            return (num + den / 2) / den;
        return -((-num + den / 2) / den);
    endfunction

    function automatic void clear_estimator(input logic mark);
        was_charging = mark;
        filt_valid = 1'b0;
        filt_level = 0;
        est_valid = 1'b0;
        last_store = '0;
        wr_ptr = 0;
        fill = 0;
        eta_min = -1;
    endfunction

    function automatic status_t estimate_runtime(input logic [31:0] now, input logic chg,
                                                 input logic [14:0] lvl);
        logic         full;
        int           filt, delta, oldest, newest, k, base, s;
        logic [31:0]  min_iv, span, dt;
        logic [63:0]  sum_t, sum_p, sum_tp, n, a_tp, b_tp, m, rate, eta_q8, t, p, lv;
        logic [127:0] sum_tt, den, num, q;
        full = chg || (lvl >= FULL_LEVEL);
        if (full || lvl == 0)
        begin
            clear_estimator(full);
            return ST_RESET;
        end
        if (was_charging)
            clear_estimator(1'b0);
        if (now < BOOT_AGE_S)
            return ST_EARLY;
        filt = int'(lvl);
        if (filt_valid)
        begin
            filt = filt_level + round_div(FILT_ALPHA * (int'(lvl) - filt_level), 256);
            if (filt > filt_level + FILT_CAP)
                filt = filt_level + FILT_CAP;
        end
        else
            filt_valid = 1'b1;
        if (filt < 0)
            filt = 0;
        if (filt > 25600)
            filt = 25600;
        if (fill > 0)
        begin
            delta = filt - hist_level[(wr_ptr + DEPTH - 1) % DEPTH];
            if (-delta > JUMP_DROP || delta > JUMP_RISE)
                return ST_JUMP;
        end
        filt_level = filt;
        min_iv = interval_ms / 1000;
        if (min_iv < 1)
            min_iv = 1;
        if (last_store != 0 && now - last_store < min_iv)
            return ST_INTERVAL;
        last_store = now;
        hist_time[wr_ptr] = now;
        hist_level[wr_ptr] = filt;
        wr_ptr = (wr_ptr + 1) % DEPTH;
        if (fill < DEPTH)
            fill++;
        if (fill < MIN_SAMPLES)
            return ST_HISTORY;
        oldest = (fill < DEPTH) ? 0 : wr_ptr;
        newest = (wr_ptr + DEPTH - 1) % DEPTH;
        span = hist_time[newest] - hist_time[oldest];
        if (span < MIN_SPAN_S)
            return ST_HISTORY;
        sum_t = 0;
        sum_p = 0;
        sum_tp = 0;
        sum_tt = 0;
        for (int i = 0; i < fill; i++)
        begin
            k = (oldest + i) % DEPTH;
            dt = hist_time[k] - hist_time[oldest];
            t = 64'(dt);
            p = 64'(hist_level[k]);
            sum_t += t;
            sum_p += p;
            sum_tt = sum_tt + 128'(t) * 128'(t);
            sum_tp += t * p;
        end
        n = 64'(fill);
        den = sum_tt * 128'(n) - 128'(sum_t) * 128'(sum_t);
        if (den == 0)
            return ST_HISTORY;
        a_tp = n * sum_tp;
        b_tp = sum_t * sum_p;
        if (a_tp >= b_tp)
            return ST_SLOPE;
        m = b_tp - a_tp;
        num = 128'(m) * 128'd1843200 + den;
        q = num / (den * 2);
        if (q < 128'd16384 || q > 128'd1966080)
            return ST_SLOPE;
        rate = q[63:0];
        if (rate * 64'(span) < 64'd235929600)
            return ST_SLOPE;
        lv = 64'(hist_level[newest]);
        eta_q8 = (lv * 64'd7864320 + rate) / (2 * rate);
        if (eta_q8 == 0 || eta_q8 >= 64'd2560000)
            return ST_SLOPE;
        if (est_valid && eta_min >= 0)
        begin
            base = eta_min * 256;
            s = base + round_div(int'(eta_q8) - base, 4);
            eta_min = (s + 128) / 256;
        end
        else
        begin
            eta_min = int'((eta_q8 + 128) / 256);
            est_valid = 1'b1;
        end
        return ST_UPDATED;
    endfunction

    task automatic send_sample(input logic [31:0] now, input logic chg, input logic [14:0] lvl,
                               input bit known = 0, input logic [14:0] k_eta = '0,
                               input status_t k_st = ST_RESET);
        estimate_t e;
        while ($urandom_range(99) < src_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, lvl, now};
        s_tuser <= chg;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        e.st = estimate_runtime(now, chg, lvl);
        e.eta = eta_min[14:0];
        if (known)
        begin
            e.eta = k_eta;
            e.st = k_st;
        end
        pending_estimates.push_back(e);
        items_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_estimates.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_interval(input logic [21:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 3'd0;
        pwdata <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        interval_ms = value;
    endtask

    task automatic run_session();
        logic [31:0] t;
        int          lvl, rate_q, len, step, iv, drop;
        bit          rising;
        iv = interval_ms / 1000;
        if (iv < 1)
            iv = 1;
        send_sample($urandom, 1'b1, 15'($urandom_range(0, 32767)));
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4: t = $urandom_range(0, 1500);
            5, 6, 7:       t = 32'hFFFF_FFFF - $urandom_range(0, 20000);
            default:       t = $urandom_range(1200, 2000000000);
        endcase
        lvl = $urandom_range(3000, 25400);
        rate_q = $urandom_range(20, 10000);
        rising = ($urandom_range(0, 9) == 0);
        len = $urandom_range(10, 60);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_sample($urandom, $urandom_range(0, 3) == 0, 15'($urandom_range(0, 32767)));
            else
            begin
                step = $urandom_range(1, (iv * 2 > 7200) ? 7200 : iv * 2 + 1);
                drop = (step * rate_q + $urandom_range(0, 3599)) / 3600;
                lvl = rising ? lvl + drop : lvl - drop;
                if (lvl < 1)
                    lvl = 1;
                if (lvl > 25400)
                    lvl = 25400;
                t += step;
                if ($urandom_range(0, 29) == 0)
                    send_sample(t, 1'b0, 15'((lvl > 3000) ? lvl - 2000 : lvl + 2000));
                else
                    send_sample(t, 1'b0, 15'(lvl));
            end
        end
    endtask

    always @(posedge clk)
    begin
        estimate_t e;
        m_tready <= ($urandom_range(99) >= snk_idle);
        if (m_tvalid && m_tready)
        begin
            if (pending_estimates.size() == 0)
            begin
                $display("%0t: unexpected output, actual eta %0d status %0d", $time,
                         $signed(m_tdata[14:0]), m_tuser);
                errors++;
            end
            else
            begin
                e = pending_estimates.pop_front();
                if (m_tdata[14:0] !== e.eta)
                begin
                    $display("%0t: eta mismatch, expected %0d actual %0d", $time,
                             $signed(e.eta), $signed(m_tdata[14:0]));
                    errors++;
                end
                if (m_tuser !== e.st)
                begin
                    $display("%0t: status mismatch, expected %0d actual %0d", $time,
                             e.st, m_tuser);
                    errors++;
                end
                if (m_tuser < 7)
                    status_seen[m_tuser]++;
            end
        end
    end

    initial
    begin
        #300000000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        sample_row_t rows [$];
        logic [21:0] settings [6];
        int          idle_src [3];
        int          idle_snk [3];
        interval_ms = INTERVAL_RESET;
        clear_estimator(1'b0);
        foreach (status_seen[i])
            status_seen[i] = 0;
        rows.push_back('{32'd100, 1'b0, 15'd10000, 1, 15'h7FFF, ST_EARLY});
        rows.push_back('{32'd5000, 1'b1, 15'd12000, 1, 15'h7FFF, ST_RESET});
        rows.push_back('{32'd5000, 1'b0, 15'd25472, 1, 15'h7FFF, ST_RESET});
        rows.push_back('{32'd5000, 1'b0, 15'd0, 1, 15'h7FFF, ST_RESET});
        rows.push_back('{32'd5000, 1'b0, 15'd32767, 1, 15'h7FFF, ST_RESET});
        rows.push_back('{32'd300, 1'b0, 15'd20000, 1, 15'h7FFF, ST_EARLY});
        rows.push_back('{32'd4294967000, 1'b0, 15'd20000, 1, 15'h7FFF, ST_HISTORY});
        rows.push_back('{32'd2000, 1'b0, 15'd10000, 1, 15'h7FFF, ST_JUMP});
        rows.push_back('{32'd2000, 1'b0, 15'd19990, 1, 15'h7FFF, ST_HISTORY});
        rows.push_back('{32'd2010, 1'b0, 15'd19990, 1, 15'h7FFF, ST_INTERVAL});
        rows.push_back('{32'd2000, 1'b0, 15'd1, 1, 15'h7FFF, ST_JUMP});
        for (int j = 0; j < 11; j++)
            rows.push_back('{32'(2300 + 300 * j), 1'b0, 15'(19900 - 120 * j), 0, '0, ST_RESET});
        rows.push_back('{32'hFFFF_FFFF, 1'b1, 15'd0, 1, 15'h7FFF, ST_RESET});

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        if (prdata !== 32'(INTERVAL_RESET))
        begin
            $display("%0t: interval readback mismatch, expected %0d actual %0d", $time,
                     INTERVAL_RESET, prdata);
            errors++;
        end
        foreach (rows[i])
            send_sample(rows[i].now, rows[i].chg, rows[i].lvl, rows[i].known,
                        rows[i].eta, rows[i].st);
        drain();

        settings = '{22'd0, 22'd3600000, 22'd15000, 22'd999, 22'd60000,
                     22'($urandom_range(1000, 120000))};
        idle_src = '{20, 72, 0};
        idle_snk = '{72, 20, 0};
        for (int seg = 0; seg < 6; seg++)
        begin
            write_interval(settings[seg]);
            src_idle = idle_src[seg / 2];
            snk_idle = idle_snk[seg / 2];
            while (items_sent < 23 + RANDOM_ITEMS * (seg + 1) / 6)
                run_session();
            drain();
        end
        repeat (300) @(posedge clk);
        $display("Sent %0d samples over six interval settings and three stall patterns.",
                 items_sent);
        $display("Status counts 0..6: %0d %0d %0d %0d %0d %0d %0d", status_seen[0],
                 status_seen[1], status_seen[2], status_seen[3], status_seen[4],
                 status_seen[5], status_seen[6]);
        if (errors == 0 && pending_estimates.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== battery_runtime_estimator_unit.f =====
rtl/core/brest_pkg.sv
rtl/core/brest_alu.sv
rtl/core/battery_runtime_estimator_unit.sv
rtl/core/brest_checker.sv
verif/tb_battery_runtime_estimator_unit.sv
